/* src/a32dec_pkg.sv */
// Package with kind codes, error codes and operand forms for the A32 decoder.
package a32dec_pkg;

    localparam logic [6:0] K_UNKNOWN   = 7'd95;
    localparam logic [6:0] K_MSR       = 7'd47;
    localparam logic [6:0] K_MRS       = 7'd48;
    localparam logic [6:0] K_CLZ       = 7'd49;
    localparam logic [6:0] K_BX        = 7'd50;
    localparam logic [6:0] K_BXJ       = 7'd51;
    localparam logic [6:0] K_BLX       = 7'd52;
    localparam logic [6:0] K_QADD      = 7'd53;
    localparam logic [6:0] K_BKPT      = 7'd57;
    localparam logic [6:0] K_SMLABB    = 7'd58;
    localparam logic [6:0] K_STR       = 7'd74;
    localparam logic [6:0] K_UNDEF     = 7'd82;
    localparam logic [6:0] K_STMDA     = 7'd83;
    localparam logic [6:0] K_B         = 7'd91;
    localparam logic [6:0] K_BL        = 7'd92;
    localparam logic [6:0] K_SWI       = 7'd93;
    localparam logic [6:0] K_SETEND    = 7'd94;

    typedef enum logic [3:0] {
        E_OK      = 4'd0,
        E_SHIFTER = 4'd1,
        E_MUL     = 4'd2,
        E_XLS     = 4'd3,
        E_MISC    = 4'd4,
        E_MSR     = 4'd5,
        E_MEDIA   = 4'd6,
        E_COPROC  = 4'd7,
        E_CPS     = 4'd8,
        E_UNCOND  = 4'd9
    } t_err;

    typedef enum logic [2:0] {
        F_IMM     = 3'd0,
        F_REG     = 3'd1,
        F_REG_IMM = 3'd2,
        F_REG_REG = 3'd3,
        F_RRX     = 3'd4
    } t_form;

    typedef struct packed {
        logic [6:0]  kind;
        logic [3:0]  cond_code;
        t_form       form;
        logic [1:0]  stype;
        logic [5:0]  samt;
        logic [31:0] imm;
        logic [2:0]  amode;
        t_err        err;
    } t_dec;

    // Data-processing kinds by {S, opcode}
    function automatic logic [6:0] dp_kind(input logic [4:0] idx);
        logic [6:0] k;
        begin
            if (idx[4]) k = 7'd12 + {3'd0, idx[3:0]};
            else if (idx[3:2] == 2'b10) k = K_UNKNOWN;
            else if (idx[3]) k = 7'd8 + {5'd0, idx[1:0]};
            else k = {4'd0, idx[2:0]};
            return k;
        end
    endfunction

    function automatic logic [6:0] mul_kind(input logic [3:0] idx);
        logic [6:0] k;
        begin
            if (idx[3]) k = 7'd33 + {4'd0, idx[2:0]};
            else if (idx[2:0] <= 3'd4) k = 7'd28 + {4'd0, idx[2:0]};
            else k = K_UNKNOWN;
            return k;
        end
    endfunction

    function automatic logic [6:0] xls_kind(input logic [2:0] idx);
        logic [6:0] k;
        begin
            unique case (idx)
                3'd1: k = 7'd41;
                3'd2: k = 7'd42;
                3'd3: k = 7'd43;
                3'd5: k = 7'd44;
                3'd6: k = 7'd45;
                3'd7: k = 7'd46;
                default: k = K_UNKNOWN;
            endcase
            return k;
        end
    endfunction

endpackage

/* src/arm_a32_instruction_decoder_top.sv */
// Single-pass A32 instruction decoder with input and result registers.
//
//  channel | signals                        | direction
//  request | i_valid, o_stall, i_instr_*    | in
//  result  | o_valid, i_stall, o_kind ...   | out
//  config  | i_cfg_we, i_cfg_wdata          | in
//
// One request a cycle while o_stall is low; an accepted request sits in the input register,
// is decoded into the result register and drives the outputs from there.
// Reset clears both valid flags and sets the unconditional-decode bit r_uncond to 1.
// A stalled result holds; the input side keeps accepting while any stage is empty.
module arm_a32_instruction_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_instr_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_kind,
    output logic [3:0]  o_cond_code,
    output logic [3:0]  o_reg_hi,
    output logic [3:0]  o_reg_mid,
    output logic [3:0]  o_reg_shift,
    output logic [3:0]  o_reg_low,
    output logic [2:0]  o_operand_form,
    output logic [1:0]  o_shift_type,
    output logic [5:0]  o_shift_amount,
    output logic [31:0] o_immediate,
    output logic [2:0]  o_addr_mode,
    output logic [3:0]  o_error_code
);
    import a32dec_pkg::*;

    logic        r_uncond;
    logic        r_in_valid;
    logic [31:0] r_word;
    logic [31:0] r_addr;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    t_dec        r_dec;
    t_dec        n_dec;
    logic        adv_out;
    logic        adv_in;

    // Advance when the next stage is empty or draining
    assign adv_out = !r_out_valid || !i_stall;
    assign adv_in  = !r_in_valid || adv_out;
    assign o_stall = !adv_in;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uncond <= 1'b1;
        end else if (i_cfg_we) begin
            r_uncond <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) begin
            r_word <= i_instr_word;
            r_addr <= i_instr_addr;
        end
    end

    // Decode
    always_comb begin
        logic [31:0] w;
        logic [3:0]  condf;
        logic        b4, b7, b20, b21, b22, b24, b25;
        logic [2:0]  puw;
        logic        special;
        logic [2:0]  lsh;
        logic [7:0]  v8;
        logic [4:0]  rot;
        logic [63:0] rr;
        logic [4:0]  sc;
        logic [31:0] off;
        logic [6:0]  k;
        t_form       sf;
        logic [1:0]  st;
        logic [5:0]  sa;
        logic        sok;
        w       = r_word;
        condf   = w[31:28];
        b4      = w[4];
        b7      = w[7];
        b20     = w[20];
        b21     = w[21];
        b22     = w[22];
        b24     = w[24];
        b25     = w[25];
        puw     = {w[24], w[23], w[21]};
        special = (w & 32'h0190_0000) == 32'h0100_0000;
        lsh     = {w[20], w[6], w[5]};
        v8      = w[7:0];
        rot     = {w[11:8], 1'b0};
        // Rotate right: low half of the doubled word shifted by rot
        rr      = {24'd0, v8, 24'd0, v8} >> rot;
        sc      = w[11:7];
        off     = {{8{w[23]}}, w[23:0]};
        k       = K_UNKNOWN;

        // Register shifter operand in bits 11:0
        sf  = F_REG;
        st  = 2'd0;
        sa  = 6'd0;
        sok = 1'b1;
        if (w[11:4] == 8'd0) begin
            sf = F_REG;
        end else if (!w[4]) begin
            st = w[6:5];
            if (st == 2'd3 && w[11:4] == 8'h06) begin
                sf = F_RRX;
            end else begin
                sf = F_REG_IMM;
                sa = ((st == 2'd1 || st == 2'd2) && sc == 5'd0) ? 6'd32 : {1'b0, sc};
            end
        end else if (!w[7]) begin
            sf = F_REG_REG;
            st = w[6:5];
        end else begin
            sok = 1'b0;
        end

        n_dec = '0;
        n_dec.kind      = K_UNKNOWN;
        n_dec.cond_code = condf;
        n_dec.form      = F_IMM;
        n_dec.err       = E_OK;

        if (condf != 4'd15 || !r_uncond) begin
            unique case (w[27:26])
                2'd0: begin
                    if ((w & 32'h0F00_00F0) == 32'h0000_0090) begin
                        k = mul_kind(w[23:20]);
                        n_dec.kind = k;
                        if (k == K_UNKNOWN) n_dec.err = E_MUL;
                    end else if (b4 && b7 && !b25) begin
                        k = xls_kind(lsh);
                        if ((puw & 3'd5) == 3'd1 || k == K_UNKNOWN) begin
                            n_dec.err = E_XLS;
                        end else begin
                            n_dec.kind  = k;
                            n_dec.amode = puw;
                            if (b22) n_dec.imm = {{24{w[11]}}, w[11:8], w[3:0]};
                            else n_dec.form = F_REG;
                        end
                    end else if (special && b25) begin
                        if (b21) begin
                            n_dec.kind = K_MSR;
                            n_dec.imm  = {27'd0, b22, w[19:16]};
                        end else begin
                            n_dec.err = E_MSR;
                        end
                    end else if (special) begin
                        if (!b7) begin
                            unique case (w[6:4])
                                3'd0: begin
                                    n_dec.kind = b21 ? K_MSR : K_MRS;
                                    n_dec.imm  = {27'd0, b22, b21 ? w[19:16] : 4'd0};
                                    if (b21) n_dec.form = F_REG;
                                end
                                3'd1: n_dec.kind = b22 ? K_CLZ : K_BX;
                                3'd2: n_dec.kind = K_BXJ;
                                3'd3: n_dec.kind = K_BLX;
                                3'd5: n_dec.kind = K_QADD + {5'd0, w[22:21]};
                                3'd7: begin
                                    n_dec.kind = K_BKPT;
                                    n_dec.imm  = {16'd0, w[19:8], w[3:0]};
                                end
                                default: n_dec.err = E_MISC;
                            endcase
                        end else begin
                            n_dec.kind = K_SMLABB + {3'd0, w[22:21], w[5], w[6]};
                        end
                    end else begin
                        k = dp_kind({b20, w[24:21]});
                        n_dec.kind = k;
                        if (b25) begin
                            n_dec.imm = rr[31:0];
                        end else if (!sok) begin
                            n_dec.err = E_SHIFTER;
                        end else begin
                            n_dec.form  = sf;
                            n_dec.stype = st;
                            n_dec.samt  = sa;
                        end
                        if (k == K_UNKNOWN) n_dec.err = E_SHIFTER;
                    end
                end
                2'd1: begin
                    if (!b4 || !b25) begin
                        n_dec.kind  = K_STR + {4'd0, !b24 && b21, b20, b22};
                        n_dec.amode = puw;
                        if (b25) begin
                            n_dec.form  = sf;
                            n_dec.stype = st;
                            n_dec.samt  = sa;
                        end else begin
                            n_dec.imm = {20'd0, w[11:0]};
                        end
                    end else if ((w & 32'h0FF0_00F0) == 32'h07F0_00F0) begin
                        n_dec.kind = K_UNDEF;
                    end else begin
                        n_dec.err = E_MEDIA;
                    end
                end
                2'd2: begin
                    if (!b25) begin
                        n_dec.kind  = K_STMDA + {4'd0, w[24:23], b20};
                        n_dec.imm   = {15'd0, b22, w[15:0]};
                        n_dec.amode = puw;
                    end else begin
                        n_dec.imm  = r_addr + 32'd8 + {off[29:0], 2'b00};
                        n_dec.kind = b24 ? K_BL : K_B;
                    end
                end
                default: begin
                    if (w[27:24] == 4'hF) begin
                        n_dec.kind = K_SWI;
                        n_dec.imm  = {8'd0, w[23:0]};
                    end else begin
                        n_dec.err = E_COPROC;
                    end
                end
            endcase
        end else begin
            n_dec.cond_code = 4'd14;
            if (w[27:20] == 8'h10) begin
                if (w[16]) begin
                    n_dec.kind = K_SETEND;
                    n_dec.imm  = {31'd0, w[9]};
                end else begin
                    n_dec.err = E_CPS;
                end
            end else begin
                n_dec.err = E_UNCOND;
            end
        end

        // Drop operand fields on error
        if (n_dec.err != E_OK) begin
            n_dec.kind  = K_UNKNOWN;
            n_dec.form  = F_IMM;
            n_dec.stype = 2'd0;
            n_dec.samt  = 6'd0;
            n_dec.imm   = 32'd0;
            n_dec.amode = 3'd0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_in_valid) begin
            r_dec      <= n_dec;
            r_out_word <= r_word;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_dec.kind;
    assign o_cond_code    = r_dec.cond_code;
    assign o_reg_hi       = r_out_word[19:16];
    assign o_reg_mid      = r_out_word[15:12];
    assign o_reg_shift    = r_out_word[11:8];
    assign o_reg_low      = r_out_word[3:0];
    assign o_operand_form = r_dec.form;
    assign o_shift_type   = r_dec.stype;
    assign o_shift_amount = r_dec.samt;
    assign o_immediate    = r_dec.imm;
    assign o_addr_mode    = r_dec.amode;
    assign o_error_code   = r_dec.err;

endmodule

/* src/a32dec_checker.sv */
// Port-level checker for the A32 decoder, bound to the top level.
module a32dec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_stall,
    input logic [6:0]  o_kind,
    input logic [3:0]  o_error_code,
    input logic [31:0] o_immediate,
    input logic [2:0]  o_operand_form
);
    import a32dec_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_immediate))
        else $error("stalled result changed");

    // Errors carry the unknown kind and clear operand fields
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != E_OK |->
        o_kind == K_UNKNOWN && o_immediate == 32'd0 && o_operand_form == F_IMM)
        else $error("error result not cleaned");

    // Unknown kind only with an error
    a_unk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_UNKNOWN |-> o_error_code != E_OK)
        else $error("unknown kind without error");

    // Input side never stalls while the result side is free
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall with empty result stage");

endmodule

bind arm_a32_instruction_decoder_top a32dec_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_stall        (o_stall),
    .o_kind         (o_kind),
    .o_error_code   (o_error_code),
    .o_immediate    (o_immediate),
    .o_operand_form (o_operand_form)
);
